// ===== sv/vsvc_pkg.sv =====
// Shared types, constants and register codes of the voxel sphere volume counter.
`default_nettype none
package vsvc_pkg;

    localparam int GRID_DIM_DEF   = 128;
    localparam int MAX_RADIUS_DEF = 32;

    localparam int COORD_W    = 24;
    localparam int SPACING_W  = 16;
    localparam int SIZE_W     = 8;
    localparam int CTR_W      = 26;
    localparam int RAD_W      = 8;
    localparam int CNT_W      = 22;
    localparam int DIV_W      = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int Q_DEPTH    = 2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_SPACING  = 3'd3,
        CFG_SIZE_X   = 3'd4,
        CFG_SIZE_Y   = 3'd5,
        CFG_SIZE_Z   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [SPACING_W-1:0]      spacing;
        logic [SIZE_W-1:0]         size_x;
        logic [SIZE_W-1:0]         size_y;
        logic [SIZE_W-1:0]         size_z;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic                    op;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cz;
        logic [RAD_W-1:0]        rad;
        logic                    clip;
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/vsvc_in_if.sv =====
// Request channel: opcode and atom fields with valid/ready.
`default_nettype none
interface vsvc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [vsvc_pkg::COORD_W-1:0]  atom_x;
    logic signed [vsvc_pkg::COORD_W-1:0]  atom_y;
    logic signed [vsvc_pkg::COORD_W-1:0]  atom_z;
    logic [vsvc_pkg::SPACING_W-1:0]       atom_radius;

    modport source (output valid, opcode, atom_x, atom_y, atom_z, atom_radius, input ready);
    modport sink   (input valid, opcode, atom_x, atom_y, atom_z, atom_radius, output ready);
endinterface
`default_nettype wire

// ===== sv/vsvc_out_if.sv =====
// Result channel: occupied count and clip flag with valid/ready.
`default_nettype none
interface vsvc_out_if;
    logic                          valid;
    logic                          ready;
    logic [vsvc_pkg::CNT_W-1:0]    occupied_count;
    logic                          radius_clipped;

    modport source (output valid, occupied_count, radius_clipped, input ready);
    modport sink   (input valid, occupied_count, radius_clipped, output ready);
endinterface
`default_nettype wire

// ===== sv/vsvc_div.sv =====
// Bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none
module vsvc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [vsvc_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [vsvc_pkg::SPACING_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [vsvc_pkg::DIV_W-1:0]      o_quot
);
    import vsvc_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [SPACING_W-1:0] r_rem;
    logic [SPACING_W-1:0] r_dsr;
    logic [DIV_W-1:0]     r_quot;
    logic [SPACING_W:0]   shifted;
    logic                 qbit;

    assign shifted = {r_rem, r_quot[DIV_W-1]};
    assign qbit    = (shifted >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], qbit};
            r_rem  <= qbit ? SPACING_W'(shifted - {1'b0, r_dsr}) : SPACING_W'(shifted);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== sv/vsvc_front.sv =====
// Front end: accepts requests, divides out centre voxels and voxel radius.
`default_nettype none
module vsvc_front #(
    parameter int MAX_RADIUS = vsvc_pkg::MAX_RADIUS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    vsvc_in_if.sink              i_req,
    input  wire vsvc_pkg::t_cfg  i_cfg,
    input  wire logic            i_hold,
    output vsvc_pkg::t_cmd       o_cmd,
    output logic                 o_cmd_vld,
    input  wire logic            i_cmd_rdy
);
    import vsvc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_PUSH} t_state;

    t_state                    r_state;
    logic [1:0]                r_sel;
    logic                      r_neg;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_az;
    logic [SPACING_W-1:0]      r_rad;
    t_cmd                      r_cmd;

    logic signed [DIV_W-1:0]   diff;
    logic [DIV_W-1:0]          dividend;
    logic [SPACING_W-1:0]      sp;
    logic                      div_done;
    logic [DIV_W-1:0]          quot;
    logic signed [CTR_W-1:0]   ctr;

    assign sp = (i_cfg.spacing == '0) ? SPACING_W'(1) : i_cfg.spacing;

    always_comb begin
        case (r_sel)
            2'd0:    diff = DIV_W'(r_ax) - DIV_W'(i_cfg.origin_x);
            2'd1:    diff = DIV_W'(r_ay) - DIV_W'(i_cfg.origin_y);
            2'd2:    diff = DIV_W'(r_az) - DIV_W'(i_cfg.origin_z);
            default: diff = $signed(DIV_W'(r_rad));
        endcase
        dividend = diff[DIV_W-1] ? DIV_W'(-diff) : DIV_W'(diff);
    end

    vsvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (dividend),
        .i_divisor  (sp),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // quotient rounds toward zero: divide magnitude, restore sign
    assign ctr = r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && !i_hold) begin
                        r_ax      <= i_req.atom_x;
                        r_ay      <= i_req.atom_y;
                        r_az      <= i_req.atom_z;
                        r_rad     <= i_req.atom_radius;
                        r_sel     <= '0;
                        r_cmd.op  <= i_req.opcode;
                        r_cmd.clip <= 1'b0;
                        r_state   <= (i_req.opcode == OP_REPORT) ? S_PUSH : S_START;
                    end
                end
                S_START: begin
                    r_neg   <= diff[DIV_W-1];
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        case (r_sel)
                            2'd0: r_cmd.cx <= ctr;
                            2'd1: r_cmd.cy <= ctr;
                            2'd2: r_cmd.cz <= ctr;
                            default: begin
                                if (quot > DIV_W'(MAX_RADIUS)) begin
                                    r_cmd.rad  <= RAD_W'(MAX_RADIUS);
                                    r_cmd.clip <= 1'b1;
                                end else begin
                                    r_cmd.rad  <= RAD_W'(quot);
                                end
                            end
                        endcase
                        r_sel   <= r_sel + 1'b1;
                        r_state <= (r_sel == 2'd3) ? S_PUSH : S_START;
                    end
                end
                S_PUSH: begin
                    if (i_cmd_rdy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !i_hold;
    assign o_cmd_vld   = (r_state == S_PUSH);
    assign o_cmd       = r_cmd;
endmodule
`default_nettype wire

// ===== sv/vsvc_fifo.sv =====
// Short request queue between front and back.
`default_nettype none
module vsvc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vsvc_pkg::t_cmd i_cmd,
    input  wire logic           i_vld,
    output logic                o_rdy,
    output vsvc_pkg::t_cmd      o_cmd,
    output logic                o_vld,
    input  wire logic           i_rdy
);
    import vsvc_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd            r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop;

    assign o_rdy = (r_cnt != (PW+1)'(Q_DEPTH));
    assign o_vld = (r_cnt != '0);
    assign push  = i_vld && o_rdy;
    assign pop   = o_vld && i_rdy;
    assign o_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ===== sv/vsvc_back.sv =====
// Back end: row sequencer, row width sqrt pipe, grid memory and counter.
`default_nettype none
module vsvc_back #(
    parameter int GRID_DIM   = vsvc_pkg::GRID_DIM_DEF,
    parameter int MAX_RADIUS = vsvc_pkg::MAX_RADIUS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire vsvc_pkg::t_cfg  i_cfg,
    input  wire vsvc_pkg::t_cmd  i_cmd,
    input  wire logic            i_cmd_vld,
    output logic                 o_cmd_rdy,
    output logic                 o_clearing,
    vsvc_out_if.source           o_rsp
);
    import vsvc_pkg::*;

    localparam int AW   = $clog2(GRID_DIM);
    localparam int ROWS = GRID_DIM * GRID_DIM;
    localparam int RAW  = 2 * AW;
    localparam int RB   = $clog2(MAX_RADIUS + 1);
    localparam int DW   = RB + 1;
    localparam int R2W  = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
    localparam int SQW  = R2W + 1;
    localparam int SW   = $clog2(GRID_DIM + 1);
    localparam int NCH  = GRID_DIM / 8;
    localparam int PCW  = $clog2(GRID_DIM + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_GEN, S_DRAIN} t_state;

    t_state                  r_state;
    logic [RAW-1:0]          r_clr_addr;
    logic signed [CTR_W-1:0] r_cx, r_cy, r_cz;
    logic [RB-1:0]           r_rad;
    logic [R2W-1:0]          r_rsq;
    logic signed [DW-1:0]    r_dy, r_dz;
    logic [CNT_W-1:0]        r_count;
    logic                    r_clip;
    logic                    r_out_vld;
    logic [CNT_W-1:0]        r_out_cnt;
    logic                    r_out_clip;

    logic [SW-1:0] sx, sy, sz;
    assign sx = (int'(i_cfg.size_x) > GRID_DIM) ? SW'(GRID_DIM) : SW'(i_cfg.size_x);
    assign sy = (int'(i_cfg.size_y) > GRID_DIM) ? SW'(GRID_DIM) : SW'(i_cfg.size_y);
    assign sz = (int'(i_cfg.size_z) > GRID_DIM) ? SW'(GRID_DIM) : SW'(i_cfg.size_z);

    logic signed [DW-1:0] rad_s;
    assign rad_s = $signed({1'b0, r_rad});

    // stage 1: row coordinates, squared offsets
    logic                    r1_vld;
    logic [SQW-1:0]          r1_sq;
    logic [RAW-1:0]          r1_addr;
    logic signed [CTR_W-1:0] gy, gz;
    logic signed [2*DW-1:0]  dy2, dz2;
    logic                    yin, zin;

    assign gy  = r_cy + CTR_W'(r_dy);
    assign gz  = r_cz + CTR_W'(r_dz);
    assign yin = !gy[CTR_W-1] && (gy < $signed(CTR_W'(sy)));
    assign zin = !gz[CTR_W-1] && (gz < $signed(CTR_W'(sz)));
    assign dy2 = r_dy * r_dy;
    assign dz2 = r_dz * r_dz;

    // stage 2: remaining squared half width
    logic             r2s_vld;
    logic [R2W-1:0]   r2s_rem;
    logic [RAW-1:0]   r2s_addr;

    // sqrt pipe, one result bit per stage
    logic [RB-1:0]  rs_vld;
    logic [RB-1:0]  rs_acc  [RB];
    logic [R2W-1:0] rs_rem  [RB];
    logic [RAW-1:0] rs_addr [RB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2s_vld <= 1'b0;
        end else begin
            r1_vld  <= (r_state == S_GEN) && yin && zin;
            r2s_vld <= r1_vld && (r1_sq <= SQW'(r_rsq));
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sq    <= SQW'($unsigned(dy2)) + SQW'($unsigned(dz2));
        r1_addr  <= {gz[AW-1:0], gy[AW-1:0]};
        r2s_rem  <= R2W'(SQW'(r_rsq) - r1_sq);
        r2s_addr <= r1_addr;
    end

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic [RB-1:0]   acc_in;
        logic [R2W-1:0]  rem_in;
        logic [RAW-1:0]  addr_in;
        logic            vld_in;
        logic [RB-1:0]   trial;
        logic [2*RB-1:0] tsq;
        if (k == 0) begin : g_first
            assign acc_in  = '0;
            assign rem_in  = r2s_rem;
            assign addr_in = r2s_addr;
            assign vld_in  = r2s_vld;
        end else begin : g_next
            assign acc_in  = rs_acc[k-1];
            assign rem_in  = rs_rem[k-1];
            assign addr_in = rs_addr[k-1];
            assign vld_in  = rs_vld[k-1];
        end
        assign trial = acc_in | (RB'(1) << (RB - 1 - k));
        assign tsq   = trial * trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rs_vld[k] <= 1'b0;
            else          rs_vld[k] <= vld_in;
        end
        always_ff @(posedge i_clk) begin
            rs_acc[k]  <= (tsq <= (2*RB)'(rem_in)) ? trial : acc_in;
            rs_rem[k]  <= rem_in;
            rs_addr[k] <= addr_in;
        end
    end

    // mask stage: x span of the row, clipped to the grid in use
    logic                    r_m_vld;
    logic [RAW-1:0]          r_m_addr;
    logic [GRID_DIM-1:0]     r_m_mask;
    logic signed [CTR_W-1:0] xlo, xhi;
    logic [GRID_DIM-1:0]     mask;

    assign xlo = r_cx - $signed(CTR_W'(rs_acc[RB-1]));
    assign xhi = r_cx + $signed(CTR_W'(rs_acc[RB-1]));

    always_comb begin
        for (int i = 0; i < GRID_DIM; i++) begin
            mask[i] = ($signed(CTR_W'(i)) >= xlo) && ($signed(CTR_W'(i)) <= xhi)
                      && (SW'(i) < sx);
        end
    end

    // grid memory: one row of x bits per (z, y)
    logic [GRID_DIM-1:0] r_grid [ROWS];
    logic [GRID_DIM-1:0] r_rd_data;
    logic                r_w_vld;
    logic [RAW-1:0]      r_w_addr;
    logic [GRID_DIM-1:0] r_w_mask;
    logic                r_lw_vld;
    logic [RAW-1:0]      r_lw_addr;
    logic [GRID_DIM-1:0] r_lw_data;
    logic [GRID_DIM-1:0] old_row, new_row, new_bits;

    // previous row write lands on the same edge as this row's read
    assign old_row  = (r_lw_vld && (r_lw_addr == r_w_addr)) ? r_lw_data : r_rd_data;
    assign new_row  = old_row | r_w_mask;
    assign new_bits = r_w_mask & ~old_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld  <= 1'b0;
            r_w_vld  <= 1'b0;
            r_lw_vld <= 1'b0;
        end else begin
            r_m_vld  <= rs_vld[RB-1];
            r_w_vld  <= r_m_vld;
            r_lw_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_addr  <= rs_addr[RB-1];
        r_m_mask  <= mask;
        r_w_addr  <= r_m_addr;
        r_w_mask  <= r_m_mask;
        r_lw_addr <= r_w_addr;
        r_lw_data <= new_row;
        r_rd_data <= r_grid[r_m_addr];
        if (r_w_vld) r_grid[r_w_addr] <= new_row;
        else if (r_state == S_CLEAR) r_grid[r_clr_addr] <= '0;
    end

    // popcount of newly set bits, two registered levels
    logic           r_c1_vld;
    logic [3:0]     r_c1_cnt [NCH];
    logic           r_c2_vld;
    logic [PCW-1:0] r_c2_sum;
    logic [PCW-1:0] chunk_sum;

    always_comb begin
        chunk_sum = '0;
        for (int c = 0; c < NCH; c++) chunk_sum = chunk_sum + PCW'(r_c1_cnt[c]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
        end else begin
            r_c1_vld <= r_w_vld;
            r_c2_vld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) r_c1_cnt[c] <= 4'($countones(new_bits[c*8 +: 8]));
        r_c2_sum <= chunk_sum;
    end

    logic              busy;
    logic [CNT_W:0]    cnt_sum;
    assign busy = r1_vld || r2s_vld || (|rs_vld) || r_m_vld || r_w_vld
                  || r_c1_vld || r_c2_vld;
    assign cnt_sum = {1'b0, r_count} + (CNT_W+1)'(r_c2_sum);

    assign o_cmd_rdy  = (r_state == S_IDLE) && (i_cmd.op == OP_ADD || !r_out_vld);
    assign o_clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_clip     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_out_vld && o_rsp.ready) r_out_vld <= 1'b0;
            if (r_c2_vld) r_count <= cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == RAW'(ROWS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_vld && o_cmd_rdy) begin
                        if (i_cmd.op == OP_ADD) begin
                            r_cx    <= i_cmd.cx;
                            r_cy    <= i_cmd.cy;
                            r_cz    <= i_cmd.cz;
                            r_rad   <= RB'(i_cmd.rad);
                            r_rsq   <= R2W'(RB'(i_cmd.rad) * RB'(i_cmd.rad));
                            r_dy    <= -$signed({1'b0, RB'(i_cmd.rad)});
                            r_dz    <= -$signed({1'b0, RB'(i_cmd.rad)});
                            r_clip  <= r_clip | i_cmd.clip;
                            r_state <= S_GEN;
                        end else begin
                            r_out_vld  <= 1'b1;
                            r_out_cnt  <= r_count;
                            r_out_clip <= r_clip;
                            r_count    <= '0;
                            r_clip     <= 1'b0;
                            r_clr_addr <= '0;
                            r_state    <= S_CLEAR;
                        end
                    end
                end
                S_GEN: begin
                    if (r_dy == rad_s) begin
                        r_dy <= -rad_s;
                        if (r_dz == rad_s) r_state <= S_DRAIN;
                        else               r_dz <= r_dz + 1'b1;
                    end else begin
                        r_dy <= r_dy + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.occupied_count = r_out_cnt;
    assign o_rsp.radius_clipped = r_out_clip;

    a_clear_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !busy)
        else $error("grid clear overlaps rows in flight");
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !busy)
        else $error("sequencer idle with rows in flight");
    a_report_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_IDLE) && $past(!busy))
        else $error("count reported before pipeline drained");
endmodule
`default_nettype wire

// ===== sv/voxel_sphere_volume_counter.sv =====
// Top level: configuration registers, front end, request queue and back end.
//
//  Channel   Dir  Handshake       Payload
//  i_req     in   valid/ready     opcode, atom_x, atom_y, atom_z, atom_radius
//  o_rsp     out  valid/ready     occupied_count, radius_clipped
//  i_cfg_*   in   write enable    i_cfg_idx, i_cfg_data
//
// Add request: front takes 4 serial divides of 25 quotient bits each, with accept
// and hand-off around them; back sweeps (2r+1)^2 grid rows at one row per cycle
// and then drains its pipeline; the grid memory's single read/write row port
// sets that row rate.
// Report request: the result is loaded into the output register, then a clear
// pass zeroes all GRID_DIM^2 grid rows. The same clear pass runs after reset;
// i_req.ready stays low while it runs.
// The queue lets the front divide the next request while the back sweeps rows;
// a result waits in the output register without stalling add requests.
`default_nettype none
module voxel_sphere_volume_counter #(
    parameter int GRID_DIM   = vsvc_pkg::GRID_DIM_DEF,
    parameter int MAX_RADIUS = vsvc_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    vsvc_in_if.sink                             i_req,
    vsvc_out_if.source                          o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [vsvc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [vsvc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vsvc_pkg::*;

    t_cfg r_cfg;
    t_cmd f_cmd, q_cmd;
    logic f_vld, f_rdy, q_vld, q_rdy, clearing;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.origin_z <= '0;
            r_cfg.spacing  <= SPACING_W'(51);
            r_cfg.size_x   <= SIZE_W'(128);
            r_cfg.size_y   <= SIZE_W'(128);
            r_cfg.size_z   <= SIZE_W'(128);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_cfg.origin_x <= $signed(i_cfg_data);
                CFG_ORIGIN_Y: r_cfg.origin_y <= $signed(i_cfg_data);
                CFG_ORIGIN_Z: r_cfg.origin_z <= $signed(i_cfg_data);
                CFG_SPACING:  r_cfg.spacing  <= i_cfg_data[SPACING_W-1:0];
                CFG_SIZE_X:   r_cfg.size_x   <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:   r_cfg.size_y   <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:   r_cfg.size_z   <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    vsvc_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cfg     (r_cfg),
        .i_hold    (clearing),
        .o_cmd     (f_cmd),
        .o_cmd_vld (f_vld),
        .i_cmd_rdy (f_rdy)
    );

    vsvc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_vld   (f_vld),
        .o_rdy   (f_rdy),
        .o_cmd   (q_cmd),
        .o_vld   (q_vld),
        .i_rdy   (q_rdy)
    );

    vsvc_back #(.GRID_DIM(GRID_DIM), .MAX_RADIUS(MAX_RADIUS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (q_cmd),
        .i_cmd_vld  (q_vld),
        .o_cmd_rdy  (q_rdy),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );
endmodule
`default_nettype wire
